### hw/rtl/assert_macros.svh
// assertion macros used by the sorted table binary search rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sbs_pkg.sv
// types and constants for the sorted table binary search block
package sbs_pkg;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] data_value;
    } sbs_req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] location;
    } sbs_rsp_t;

endpackage

### hw/rtl/sorted_table_binary_search.sv
// sorted table binary search: write/search requests over one synchronous table memory
// write transfer: stored in the table at the accepting edge, no response, next request at once
// search transfer: each probe is a registered table read in S_CHECK, then a compare in S_CMP;
//   the search ends in S_DONE, which loads the response register once the output slot is free
// one search at a time: the next request is taken in the cycle after the response loads
// reset clears entry_count and the control state; table contents stay undefined until written
`include "assert_macros.svh"

module sorted_table_binary_search
    import sbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  sbs_req_t           req,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output sbs_rsp_t           rsp,
    // entry_count register
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    // address width, saturated count width, signed pointer width
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PW    = IW + 2;

    localparam logic signed [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic signed [PW-1:0] PTR_ZERO = PW'(0);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_DONE
    } state_t;

    state_t                    state_reg,   state_next;
    logic [COUNT_W-1:0]        count_reg,   count_next;
    logic signed [VALUE_W-1:0] key_reg,     key_next;
    logic signed [PW-1:0]      left_reg,    left_next;
    logic signed [PW-1:0]      right_reg,   right_next;
    logic signed [PW-1:0]      mid_reg,     mid_next;
    logic                      found_reg,   found_next;
    logic [INDEX_W-1:0]        loc_reg,     loc_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    sbs_rsp_t                  rsp_reg,     rsp_next;

    // table memory, one write or one read per cycle
    logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                 tbl_we;
    logic                 rd_en;
    logic [CNT_W-1:0]     cnt_sat;
    logic signed [PW-1:0] cnt_ext;
    logic [PW:0]          ptr_sum;
    logic signed [PW-1:0] mid_w;
    logic                 slot_free;
    logic                 wr_in_range;

    // counts above the table size act as the full table
    assign cnt_sat = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(count_reg);
    assign cnt_ext = PW'(cnt_sat);

    // floor midpoint; both pointers are non-negative whenever it is used
    assign ptr_sum = {left_reg[PW-1], left_reg} + {right_reg[PW-1], right_reg};
    assign mid_w   = ptr_sum[PW:1];

    assign wr_in_range = 32'(req.entry_index) < 32'(TABLE_DEPTH);
    assign slot_free   = !rsp_valid_reg || rsp_ready;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        key_next       = key_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        loc_next       = loc_reg;
        rsp_next       = rsp_reg;
        // the pending response leaves on its transfer
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        tbl_we         = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_SEARCH)
                    begin
                        key_next   = req.data_value;
                        left_next  = PTR_ZERO;
                        right_next = cnt_ext - PTR_ONE;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        // writes past the table are dropped
                        tbl_we = wr_in_range;
                    end
                end
            end
            S_CHECK:
            begin
                if (left_reg <= right_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid_w;
                    state_next = S_CMP;
                end
                else
                begin
                    // range exhausted, key not present
                    found_next = 1'b0;
                    loc_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                priority if (rd_data_reg == key_reg)
                begin
                    found_next = 1'b1;
                    loc_next   = INDEX_W'(mid_reg[IW-1:0]);
                    state_next = S_DONE;
                end
                else if (rd_data_reg < key_reg)
                begin
                    left_next  = mid_reg + PTR_ONE;
                    state_next = S_CHECK;
                end
                else
                begin
                    right_next = mid_reg - PTR_ONE;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (slot_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.found    = found_reg;
                    rsp_next.location = loc_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            key_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            mid_reg       <= '0;
            found_reg     <= 1'b0;
            loc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            mid_reg       <= mid_next;
            found_reg     <= found_next;
            loc_reg       <= loc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // writes happen only in idle and reads only mid-search, so no overlap
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[IW'(req.entry_index)] <= req.data_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[mid_w[IW-1:0]];
        end
    end

    // a read is always followed by its compare
    `ASSERT_NEXT(a_read_then_cmp, rd_en, state_reg == S_CMP, "read not followed by compare")
    // the probe lies inside the live search range
    `ASSERT_NOW(a_mid_in_range, state_reg == S_CMP,
        (left_reg <= mid_reg) && (mid_reg <= right_reg) && (mid_reg >= PTR_ZERO),
        "probe outside search range")
    // finishing with a free output slot presents a response
    `ASSERT_NEXT(a_rsp_loaded, (state_reg == S_DONE) && slot_free, rsp_valid_reg,
        "finished search produced no response")

endmodule
